// File: rtl/core/sha256_pkg.sv
// Shared constants and round functions for the SHA-256 stream hasher.
package sha256_pkg;

    localparam int unsigned WORD_W     = 32;
    localparam int unsigned BLK_WORDS  = 16;
    localparam int unsigned COUNT_W    = 61;
    localparam int unsigned DIGEST_W   = 64;
    localparam logic [7:0]  PAD_MARK   = 8'h80;
    localparam logic [5:0]  LEN_START  = 6'd56;
    localparam logic [5:0]  LAST_ZERO  = 6'd55;
    localparam logic [5:0]  LAST_ROUND = 6'd63;

    typedef logic [WORD_W-1:0] t_word;

    function automatic t_word init_hash(input logic [2:0] idx);
        t_word v;
        case (idx)
            3'd0:    v = 32'h6a09e667;
            3'd1:    v = 32'hbb67ae85;
            3'd2:    v = 32'h3c6ef372;
            3'd3:    v = 32'ha54ff53a;
            3'd4:    v = 32'h510e527f;
            3'd5:    v = 32'h9b05688c;
            3'd6:    v = 32'h1f83d9ab;
            default: v = 32'h5be0cd19;
        endcase
        return v;
    endfunction

    localparam t_word ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic t_word rotr(input t_word x, input int unsigned n);
        return (x >> n) | (x << (WORD_W - n));
    endfunction

    function automatic t_word big_s0(input t_word x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic t_word big_s1(input t_word x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic t_word small_s0(input t_word x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic t_word small_s1(input t_word x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

// File: rtl/core/sha256_stream_if.sv
// Valid/ready channel interfaces for message bytes and digests.
interface sha256_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;

    modport source (output valid, data_byte, byte_present, end_of_message, input ready);
    modport sink   (input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

interface sha256_digest_if;
    logic        valid;
    logic        ready;
    logic [63:0] digest_bits_255_192;
    logic [63:0] digest_bits_191_128;
    logic [63:0] digest_bits_127_64;
    logic [63:0] digest_bits_63_0;

    modport source (output valid, digest_bits_255_192, digest_bits_191_128,
                    digest_bits_127_64, digest_bits_63_0, input ready);
    modport sink   (input valid, digest_bits_255_192, digest_bits_191_128,
                    digest_bits_127_64, digest_bits_63_0, output ready);
endinterface

// File: rtl/core/sha256_stream_hasher.sv
// SHA-256 stream hasher top level: byte intake, padding, round engine.
//
// i_in carries one item per transfer: a message byte (used when byte_present
// is set) and an end_of_message flag. o_out carries the 256-bit digest as
// four 64-bit words, one transfer per finished message.
// Bytes are taken only while idle; every fourth byte is written as a word
// into the block RAM. When a 64-byte block fills, the input stalls during
// RAM read-out into the schedule window, the rounds and the hash update,
// all run by the single round unit. On end of message the pad bytes are
// generated one per cycle (9 to 72 bytes), the last one or two blocks are
// compressed, and the digest is offered on o_out. The digest is held until
// it is taken; no input is accepted meanwhile. After the transfer the
// hash, byte count and position return to their start values for the
// next message. Reset (i_rst_n low, synchronous) loads the initial hash
// values and clears the count; the block RAM needs no clearing, as every
// word is written before it is read.
module sha256_stream_hasher (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    sha256_byte_if.sink            i_in,
    sha256_digest_if.source        o_out
);
    typedef enum logic [2:0] {S_IDLE, S_PAD, S_LOAD, S_ROUND, S_FINAL, S_OUT} t_state;

    t_state                       r_state;
    logic [5:0]                   r_pos;
    logic [5:0]                   r_rnd;
    logic [sha256_pkg::COUNT_W-1:0] r_count;
    logic [23:0]                  r_word;
    logic                         r_padding, r_first, r_len, r_last;
    sha256_pkg::t_word            r_hash [8];
    sha256_pkg::t_word            r_v    [8];
    sha256_pkg::t_word            r_win  [16];

    logic                         v_wr;
    logic [7:0]                   v_byte;
    logic [63:0]                  v_bits;
    logic [7:0]                   v_len_byte;
    logic                         ram_we;
    sha256_pkg::t_word            ram_rdata;
    sha256_pkg::t_word            v_t1, v_t2, v_wnew;
    logic                         in_xfer, out_xfer;

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = (r_state == S_OUT);
    assign in_xfer     = i_in.valid && i_in.ready;
    assign out_xfer    = o_out.valid && o_out.ready;

    assign o_out.digest_bits_255_192 = {r_hash[0], r_hash[1]};
    assign o_out.digest_bits_191_128 = {r_hash[2], r_hash[3]};
    assign o_out.digest_bits_127_64  = {r_hash[4], r_hash[5]};
    assign o_out.digest_bits_63_0    = {r_hash[6], r_hash[7]};

    always_comb begin
        v_bits     = {r_count, 3'b000};
        v_len_byte = v_bits[8 * (3'd7 - r_pos[2:0]) +: 8];
        if (r_state == S_PAD) begin
            v_wr   = 1'b1;
            v_byte = r_first ? sha256_pkg::PAD_MARK : (r_len ? v_len_byte : 8'h00);
        end else begin
            v_wr   = in_xfer && i_in.byte_present;
            v_byte = i_in.data_byte;
        end
        ram_we = v_wr && (r_pos[1:0] == 2'd3);
    end

    always_comb begin
        v_t1 = r_v[7] + sha256_pkg::big_s1(r_v[4])
             + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
             + sha256_pkg::ROUND_K[r_rnd] + r_win[0];
        v_t2 = sha256_pkg::big_s0(r_v[0])
             + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
        v_wnew = sha256_pkg::small_s1(r_win[14]) + r_win[9]
               + sha256_pkg::small_s0(r_win[1]) + r_win[0];
    end

    sha256_ram #(
        .WIDTH(sha256_pkg::WORD_W),
        .DEPTH(sha256_pkg::BLK_WORDS)
    ) u_blk_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_pos[5:2]),
        .i_wdata ({r_word, v_byte}),
        .i_raddr (r_rnd[3:0]),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pos     <= '0;
            r_rnd     <= '0;
            r_count   <= '0;
            r_padding <= 1'b0;
            r_first   <= 1'b0;
            r_len     <= 1'b0;
            r_last    <= 1'b0;
            for (int i = 0; i < 8; i++) begin
                r_hash[i] <= sha256_pkg::init_hash(3'(i));
            end
        end else begin
            // byte intake, shared by message and pad bytes
            if (v_wr) begin
                r_word <= {r_word[15:0], v_byte};
                r_pos  <= r_pos + 6'd1;
                if (r_state == S_PAD) begin
                    r_first <= 1'b0;
                    if (!r_len && r_pos == sha256_pkg::LAST_ZERO) begin
                        r_len <= 1'b1;
                    end
                    if (r_len && r_pos == sha256_pkg::LAST_ROUND) begin
                        r_last <= 1'b1;
                    end
                end else begin
                    r_count <= r_count + 1'b1;
                end
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        if (i_in.end_of_message) begin
                            r_padding <= 1'b1;
                            r_first   <= 1'b1;
                        end
                        if (v_wr && r_pos == sha256_pkg::LAST_ROUND) begin
                            r_state <= S_LOAD;
                            r_rnd   <= '0;
                        end else if (i_in.end_of_message) begin
                            r_state <= S_PAD;
                        end
                    end
                end
                S_PAD: begin
                    if (r_pos == sha256_pkg::LAST_ROUND) begin
                        r_state <= S_LOAD;
                        r_rnd   <= '0;
                    end
                end
                S_LOAD: begin
                    if (r_rnd == 6'd0) begin
                        for (int i = 0; i < 8; i++) begin
                            r_v[i] <= r_hash[i];
                        end
                    end else begin
                        // shift in the word read last cycle
                        for (int i = 0; i < 15; i++) begin
                            r_win[i] <= r_win[i+1];
                        end
                        r_win[15] <= ram_rdata;
                    end
                    if (r_rnd == 6'(sha256_pkg::BLK_WORDS)) begin
                        r_rnd   <= '0;
                        r_state <= S_ROUND;
                    end else begin
                        r_rnd <= r_rnd + 6'd1;
                    end
                end
                S_ROUND: begin
                    r_v[7] <= r_v[6];
                    r_v[6] <= r_v[5];
                    r_v[5] <= r_v[4];
                    r_v[4] <= r_v[3] + v_t1;
                    r_v[3] <= r_v[2];
                    r_v[2] <= r_v[1];
                    r_v[1] <= r_v[0];
                    r_v[0] <= v_t1 + v_t2;
                    for (int i = 0; i < 15; i++) begin
                        r_win[i] <= r_win[i+1];
                    end
                    r_win[15] <= v_wnew;
                    r_rnd     <= r_rnd + 6'd1;
                    if (r_rnd == sha256_pkg::LAST_ROUND) begin
                        r_state <= S_FINAL;
                    end
                end
                S_FINAL: begin
                    for (int i = 0; i < 8; i++) begin
                        r_hash[i] <= r_hash[i] + r_v[i];
                    end
                    if (r_last) begin
                        r_state <= S_OUT;
                    end else if (r_padding) begin
                        r_state <= S_PAD;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_OUT: begin
                    if (out_xfer) begin
                        for (int i = 0; i < 8; i++) begin
                            r_hash[i] <= sha256_pkg::init_hash(3'(i));
                        end
                        r_count   <= '0;
                        r_pos     <= '0;
                        r_padding <= 1'b0;
                        r_first   <= 1'b0;
                        r_len     <= 1'b0;
                        r_last    <= 1'b0;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !i_in.ready)
        else $error("digest offered while input open");

    a_eom_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_in.end_of_message) |=> !i_in.ready)
        else $error("input still open after end of message");

    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_xfer |=> (r_count == '0 && r_pos == '0 && !r_padding))
        else $error("message state not restarted after digest transfer");

    a_pad_only_when_padding: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PAD) |-> r_padding)
        else $error("pad bytes generated outside end of message");
endmodule

// File: rtl/core/sha256_ram.sv
// Generic single-port-write, registered-read RAM.
module sha256_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
